// File: hdl/hti_pkg.sv
`default_nettype none

package hti_pkg;

   // Grid geometry and position format
   localparam int GRID_W    = 256;
   localparam int GRID_H    = 256;
   localparam int FRAC_BITS = 8;

   localparam int POS_W    = 16;
   localparam int CELL_W   = 8;
   localparam int HEIGHT_W = 16;
   localparam int COORD_W  = POS_W - FRAC_BITS;
   localparam int ADDR_W   = 16;
   localparam int DEPTH    = 65536;

   // Interpolation arithmetic widths
   localparam int DIFF_W = HEIGHT_W + 1;
   localparam int COEF_W = FRAC_BITS + 2;
   localparam int PROD_W = DIFF_W + COEF_W;
   localparam int ACC_W  = FRAC_BITS + 21;
   localparam int RES_W  = ACC_W - FRAC_BITS;

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      C00 = 2'd0,
      C10 = 2'd1,
      C01 = 2'd2,
      C11 = 2'd3
   } corner_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_RD00,
      ST_RD10,
      ST_RD01,
      ST_RD11,
      ST_CAP,
      ST_MUL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       mem_we;
      logic       mem_re;
      corner_type addr_sel;
      logic       cap_en;
      corner_type cap_sel;
      logic       mul_en;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: hdl/hti_ctrl.sv
`default_nettype none

module hti_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_opcode,
   output logic                    req_ready,
   input  wire hti_pkg::status_type status,
   output hti_pkg::cmd_type        cmd
);

   hti_pkg::state_type state_ff;
   hti_pkg::state_type state_in;

   // Advance the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hti_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hti_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == hti_pkg::OP_QUERY) begin
                  state_in = hti_pkg::ST_RD00;
               end else begin
                  state_in = hti_pkg::ST_WRITE;
               end
            end
         end
         hti_pkg::ST_WRITE: state_in = hti_pkg::ST_DONE;
         hti_pkg::ST_RD00:  state_in = hti_pkg::ST_RD10;
         hti_pkg::ST_RD10:  state_in = hti_pkg::ST_RD01;
         hti_pkg::ST_RD01:  state_in = hti_pkg::ST_RD11;
         hti_pkg::ST_RD11:  state_in = hti_pkg::ST_CAP;
         hti_pkg::ST_CAP:   state_in = hti_pkg::ST_MUL;
         hti_pkg::ST_MUL:   state_in = hti_pkg::ST_DONE;
         hti_pkg::ST_DONE: begin
            if (status.out_free) begin
               state_in = hti_pkg::ST_IDLE;
            end
         end
         default: state_in = hti_pkg::ST_IDLE;
      endcase
   end

   // Commands: each read state presents one corner; every read state after the first also captures the previous one
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.addr_sel = hti_pkg::C00;
      cmd.cap_sel  = hti_pkg::C00;
      case (state_ff)
         hti_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         hti_pkg::ST_WRITE: begin
            cmd.mem_we = 1'b1;
         end
         hti_pkg::ST_RD00: begin
            cmd.mem_re   = 1'b1;
            cmd.addr_sel = hti_pkg::C00;
         end
         hti_pkg::ST_RD10: begin
            cmd.mem_re   = 1'b1;
            cmd.addr_sel = hti_pkg::C10;
            cmd.cap_en   = 1'b1;
            cmd.cap_sel  = hti_pkg::C00;
         end
         hti_pkg::ST_RD01: begin
            cmd.mem_re   = 1'b1;
            cmd.addr_sel = hti_pkg::C01;
            cmd.cap_en   = 1'b1;
            cmd.cap_sel  = hti_pkg::C10;
         end
         hti_pkg::ST_RD11: begin
            cmd.mem_re   = 1'b1;
            cmd.addr_sel = hti_pkg::C11;
            cmd.cap_en   = 1'b1;
            cmd.cap_sel  = hti_pkg::C01;
         end
         hti_pkg::ST_CAP: begin
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = hti_pkg::C11;
         end
         hti_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
         end
         hti_pkg::ST_DONE: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/hti_datapath.sv
`default_nettype none

module hti_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire hti_pkg::cmd_type                    cmd,
   output hti_pkg::status_type                      status,
   input  wire logic                                req_opcode,
   input  wire logic [hti_pkg::POS_W-1:0]           req_pos_x,
   input  wire logic [hti_pkg::POS_W-1:0]           req_pos_y,
   input  wire logic [hti_pkg::CELL_W-1:0]          req_cell_x,
   input  wire logic [hti_pkg::CELL_W-1:0]          req_cell_y,
   input  wire logic signed [hti_pkg::HEIGHT_W-1:0] req_new_height,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [hti_pkg::HEIGHT_W-1:0]      rsp_interpolated_height,
   output logic signed [hti_pkg::HEIGHT_W-1:0]      rsp_lowest_corner,
   output logic signed [hti_pkg::HEIGHT_W-1:0]      rsp_highest_corner
);

   localparam int FB = hti_pkg::FRAC_BITS;
   localparam int CW = hti_pkg::COORD_W;
   localparam int AW = hti_pkg::ADDR_W;
   localparam int HW = hti_pkg::HEIGHT_W;

   localparam logic [CW:0]   X_LAST    = (CW + 1)'(hti_pkg::GRID_W - 1);
   localparam logic [CW:0]   Y_LAST    = (CW + 1)'(hti_pkg::GRID_H - 1);
   localparam logic [AW-1:0] ROW_PITCH = AW'(hti_pkg::GRID_W);
   localparam logic [hti_pkg::CELL_W:0] CELL_X_LIM = (hti_pkg::CELL_W + 1)'(hti_pkg::GRID_W);
   localparam logic [hti_pkg::CELL_W:0] CELL_Y_LIM = (hti_pkg::CELL_W + 1)'(hti_pkg::GRID_H);
   localparam logic [FB:0]   ONE       = (FB + 1)'(1) << FB;
   localparam logic signed [hti_pkg::ACC_W-1:0] HALF = hti_pkg::ACC_W'(1) << (FB - 1);
   localparam logic signed [hti_pkg::RES_W-1:0] RES_MAX = hti_pkg::RES_W'(32767);
   localparam logic signed [hti_pkg::RES_W-1:0] RES_MIN = -(hti_pkg::RES_W'(32768));

   // Request registers
   logic                   is_query_ff;
   logic [CW-1:0]          ix_ff;
   logic [CW-1:0]          iy_ff;
   logic [FB-1:0]          fx_ff;
   logic [FB-1:0]          fy_ff;
   logic [hti_pkg::CELL_W-1:0] wx_ff;
   logic [hti_pkg::CELL_W-1:0] wy_ff;
   logic [HW-1:0]          wh_ff;

   // Height memory and corner registers
   logic [HW-1:0]          mem [0:hti_pkg::DEPTH-1];
   logic [HW-1:0]          rd_data_ff;
   logic signed [HW-1:0]   h_ff [0:3];

   // Product registers
   logic signed [HW-1:0]              base_ff;
   logic signed [hti_pkg::PROD_W-1:0] p1_ff;
   logic signed [hti_pkg::PROD_W-1:0] p2_ff;

   // Output register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic signed [HW-1:0]  rsp_height_ff;
   logic signed [HW-1:0]  rsp_low_ff;
   logic signed [HW-1:0]  rsp_high_ff;

   logic [CW:0]    x0;
   logic [CW:0]    x1;
   logic [CW:0]    y0;
   logic [CW:0]    y1;
   logic [CW:0]    cx;
   logic [CW:0]    cy;
   logic [AW-1:0]  rd_addr;
   logic [AW-1:0]  wr_addr;
   logic [AW-1:0]  mem_addr;
   logic           wr_in_range;

   logic [FB:0]                       fsum;
   logic                              lower_tri;
   logic signed [hti_pkg::COEF_W-1:0] coef1;
   logic signed [hti_pkg::COEF_W-1:0] coef2;
   logic signed [hti_pkg::DIFF_W-1:0] diff1;
   logic signed [hti_pkg::DIFF_W-1:0] diff2;
   logic signed [HW-1:0]              base;

   logic signed [hti_pkg::ACC_W-1:0] acc;
   logic signed [hti_pkg::RES_W-1:0] acc_sh;
   logic signed [HW-1:0]             res_sat;
   logic signed [HW-1:0]             lo_a;
   logic signed [HW-1:0]             lo_b;
   logic signed [HW-1:0]             hi_a;
   logic signed [HW-1:0]             hi_b;
   logic signed [HW-1:0]             lo_all;
   logic signed [HW-1:0]             hi_all;

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         is_query_ff <= (req_opcode == hti_pkg::OP_QUERY);
         ix_ff       <= req_pos_x[hti_pkg::POS_W-1:FB];
         iy_ff       <= req_pos_y[hti_pkg::POS_W-1:FB];
         fx_ff       <= req_pos_x[FB-1:0];
         fy_ff       <= req_pos_y[FB-1:0];
         wx_ff       <= req_cell_x;
         wy_ff       <= req_cell_y;
         wh_ff       <= req_new_height;
      end
   end

   // Select a corner, clamp its coordinates to the grid edge and form its address
   always_comb begin
      x0 = {1'b0, ix_ff};
      y0 = {1'b0, iy_ff};
      x1 = x0 + (CW + 1)'(1);
      y1 = y0 + (CW + 1)'(1);
      case (cmd.addr_sel)
         hti_pkg::C00: begin cx = x0; cy = y0; end
         hti_pkg::C10: begin cx = x1; cy = y0; end
         hti_pkg::C01: begin cx = x0; cy = y1; end
         hti_pkg::C11: begin cx = x1; cy = y1; end
         default:      begin cx = x0; cy = y0; end
      endcase
      if (cx > X_LAST) cx = X_LAST;
      if (cy > Y_LAST) cy = Y_LAST;
      rd_addr = AW'(cy) * ROW_PITCH + AW'(cx);
   end

   assign wr_addr     = AW'(wy_ff) * ROW_PITCH + AW'(wx_ff);
   assign wr_in_range = ({1'b0, wx_ff} < CELL_X_LIM) && ({1'b0, wy_ff} < CELL_Y_LIM);
   assign mem_addr    = cmd.mem_we ? wr_addr : rd_addr;

   // Single-port height memory
   always_ff @(posedge clock) begin
      if (cmd.mem_we && wr_in_range) begin
         mem[mem_addr] <= wh_ff;
      end
      if (cmd.mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   // Hold each corner as it returns from memory
   always_ff @(posedge clock) begin
      if (cmd.cap_en) begin
         h_ff[cmd.cap_sel] <= rd_data_ff;
      end
   end

   // Pick triangle, differences and weights
   always_comb begin
      fsum      = {1'b0, fx_ff} + {1'b0, fy_ff};
      lower_tri = (fsum <= ONE);
      if (lower_tri) begin
         base  = h_ff[hti_pkg::C00];
         coef1 = $signed({2'b00, fx_ff});
         coef2 = $signed({2'b00, fy_ff});
         diff1 = hti_pkg::DIFF_W'(h_ff[hti_pkg::C10]) - hti_pkg::DIFF_W'(h_ff[hti_pkg::C00]);
         diff2 = hti_pkg::DIFF_W'(h_ff[hti_pkg::C01]) - hti_pkg::DIFF_W'(h_ff[hti_pkg::C00]);
      end else begin
         base  = h_ff[hti_pkg::C11];
         coef1 = $signed({2'b00, fx_ff} - {1'b0, ONE});
         coef2 = $signed({2'b00, fy_ff} - {1'b0, ONE});
         diff1 = hti_pkg::DIFF_W'(h_ff[hti_pkg::C11]) - hti_pkg::DIFF_W'(h_ff[hti_pkg::C01]);
         diff2 = hti_pkg::DIFF_W'(h_ff[hti_pkg::C11]) - hti_pkg::DIFF_W'(h_ff[hti_pkg::C10]);
      end
   end

   // Register the two weighted differences
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         base_ff <= base;
         p1_ff   <= hti_pkg::PROD_W'(coef1) * hti_pkg::PROD_W'(diff1);
         p2_ff   <= hti_pkg::PROD_W'(coef2) * hti_pkg::PROD_W'(diff2);
      end
   end

   // Sum, round half up, saturate; corner min and max
   always_comb begin
      acc = (hti_pkg::ACC_W'(base_ff) <<< FB) + hti_pkg::ACC_W'(p1_ff)
          + hti_pkg::ACC_W'(p2_ff) + HALF;
      acc_sh = hti_pkg::RES_W'(acc >>> FB);
      if (acc_sh > RES_MAX) begin
         res_sat = HW'(RES_MAX);
      end else if (acc_sh < RES_MIN) begin
         res_sat = HW'(RES_MIN);
      end else begin
         res_sat = HW'(acc_sh);
      end
      lo_a   = (h_ff[0] < h_ff[1]) ? h_ff[0] : h_ff[1];
      lo_b   = (h_ff[2] < h_ff[3]) ? h_ff[2] : h_ff[3];
      hi_a   = (h_ff[0] > h_ff[1]) ? h_ff[0] : h_ff[1];
      hi_b   = (h_ff[2] > h_ff[3]) ? h_ff[2] : h_ff[3];
      lo_all = (lo_a < lo_b) ? lo_a : lo_b;
      hi_all = (hi_a > hi_b) ? hi_a : hi_b;
   end

   // Output register: load a finished item, drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (is_query_ff) begin
            rsp_height_ff <= res_sat;
            rsp_low_ff    <= lo_all;
            rsp_high_ff   <= hi_all;
         end else begin
            rsp_height_ff <= '0;
            rsp_low_ff    <= '0;
            rsp_high_ff   <= '0;
         end
      end
   end

   assign status.out_free         = !rsp_valid_ff || rsp_ready;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_interpolated_height = rsp_height_ff;
   assign rsp_lowest_corner       = rsp_low_ff;
   assign rsp_highest_corner      = rsp_high_ff;

endmodule

`default_nettype wire

// File: hdl/heightmap_triangle_interpolator.sv
`default_nettype none

// Heightmap triangle interpolator. Holds a 256 x 256 grid of signed Q4.12
// heights in one single-port memory (not cleared by reset; read only points
// that were written). A write item (opcode 0) stores one height and returns
// an all-zero result. A query item (opcode 1) gives a Q8.8 position; the
// four corners of its cell (clamped to the grid edge) are read one per
// cycle through the single memory port, the cell is split along its
// diagonal, and the rounded, saturated height plus the corner minimum and
// maximum come back after the four reads, the last capture, the multiply
// and the output load. Items are handled one at a time: the next item is
// taken only in the idle state, once the previous item has been loaded
// into the output register. The result sits in an output register, so the
// next item is taken while a result still waits for rsp_ready; a second
// finished result holds the sequencer until the first one is taken.
module heightmap_triangle_interpolator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_opcode,
   input  wire logic [hti_pkg::POS_W-1:0]           req_pos_x,
   input  wire logic [hti_pkg::POS_W-1:0]           req_pos_y,
   input  wire logic [hti_pkg::CELL_W-1:0]          req_cell_x,
   input  wire logic [hti_pkg::CELL_W-1:0]          req_cell_y,
   input  wire logic signed [hti_pkg::HEIGHT_W-1:0] req_new_height,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [hti_pkg::HEIGHT_W-1:0]      rsp_interpolated_height,
   output logic signed [hti_pkg::HEIGHT_W-1:0]      rsp_lowest_corner,
   output logic signed [hti_pkg::HEIGHT_W-1:0]      rsp_highest_corner
);

   hti_pkg::cmd_type    cmd;
   hti_pkg::status_type status;

   hti_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   hti_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_opcode              (req_opcode),
      .req_pos_x               (req_pos_x),
      .req_pos_y               (req_pos_y),
      .req_cell_x              (req_cell_x),
      .req_cell_y              (req_cell_y),
      .req_new_height          (req_new_height),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_interpolated_height (rsp_interpolated_height),
      .rsp_lowest_corner       (rsp_lowest_corner),
      .rsp_highest_corner      (rsp_highest_corner)
   );

endmodule

`default_nettype wire
